// File: hdl/mpeb_pkg.sv
`default_nettype none

package mpeb_pkg;

   // Table and geometry constants
   localparam int MaxEntries      = 4;
   localparam int SectorsPerTrack = 63;
   localparam int MinHeads        = 16;
   localparam int MinHeadShift    = 4;      // log2(MinHeads)
   localparam int HeadSteps       = 4;      // 16 -> 32 -> 64 -> 128 -> 256
   localparam int MaxHeads        = 255;    // 256 heads are reported as 255
   localparam int HeadsWidth      = 9;      // holds 256 before the fold
   localparam int CylLimit        = 1024;
   // heads double while (total / heads) / 63 > 1024, i.e. total >= heads * 1025 * 63
   localparam int HeadLimitSectors = (CylLimit + 1) * SectorsPerTrack;
   localparam int PercentScale    = 100;
   localparam logic [7:0] BootActive = 8'h80;

   // CSR map
   localparam logic [1:0] CsrTotalSectors = 2'd0;

   // Widths
   localparam int SectorsWidth    = 32;
   localparam int PctWidth        = 7;
   localparam int EntryCountWidth = $clog2(MaxEntries + 1);
   localparam int CylSizeWidth    = $clog2(MaxHeads * SectorsPerTrack + 1);
   // largest cylinder count comes with the most heads
   localparam int CylWidth        = $clog2(64'd4294967295 / (MaxHeads * SectorsPerTrack) + 1);
   localparam int PctProdWidth    = CylWidth + PctWidth;
   localparam int MulWidth        = CylWidth + CylSizeWidth;

   // product / 100 as a reciprocal multiply, exact for any PctProdWidth-bit product
   localparam int     PctRecipShift  = PctProdWidth + $clog2(PercentScale);
   localparam longint PctRecip       = ((64'd1 << PctRecipShift) + PercentScale - 1)
                                       / PercentScale;
   localparam int     PctRecipWidth  = PctRecipShift - $clog2(PercentScale) + 1;
   localparam int     PctScaledWidth = PctProdWidth + PctRecipWidth;

   typedef enum logic [1:0] {
      StatusWritten = 2'd0,
      StatusSkipped = 2'd1,
      StatusAbort   = 2'd2,
      StatusIgnored = 2'd3
   } status_type;

   typedef enum logic {
      PcylQuotient,
      PcylRemain
   } pcyl_sel_type;

   typedef enum logic [1:0] {
      MulPercent,
      MulStart,
      MulCount
   } mul_sel_type;

   typedef struct packed {
      logic         first_of_table;
      logic         active;
      logic [7:0]   part_type;
      logic [6:0]   size_percent;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]   status;
      logic [7:0]   boot_flag;
      logic         start_head;
      logic [7:0]   start_sector_code;
      logic [7:0]   start_cyl_low;
      logic [7:0]   type_code;
      logic [7:0]   end_head;
      logic [7:0]   end_sector_code;
      logic [7:0]   end_cyl_low;
      logic [31:0]  lba_start;
      logic [31:0]  lba_count;
   } rsp_payload_type;

   // controller -> datapath
   typedef struct packed {
      logic         load_req;
      logic         div_start;
      logic         tot_load;
      logic         pcyl_load;
      pcyl_sel_type pcyl_sel;
      logic         mul_load;
      mul_sel_type  mul_sel;
      logic         finish;
      status_type   rsp_status;
   } mpeb_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic ignore;
      logic pct_zero;
      logic div_done;
      logic pcyl_zero;
      logic no_space;
      logic out_free;
   } mpeb_stat_type;

endpackage

`default_nettype wire

// File: hdl/mpeb_channels.sv
`default_nettype none

interface mpeb_req_if;
   logic       valid;
   logic       ready;
   logic       first_of_table;
   logic       active;
   logic [7:0] part_type;
   logic [6:0] size_percent;

   modport source (output valid, first_of_table, active, part_type, size_percent,
                   input ready);
   modport sink (input valid, first_of_table, active, part_type, size_percent,
                 output ready);
endinterface

interface mpeb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  boot_flag;
   logic        start_head;
   logic [7:0]  start_sector_code;
   logic [7:0]  start_cyl_low;
   logic [7:0]  type_code;
   logic [7:0]  end_head;
   logic [7:0]  end_sector_code;
   logic [7:0]  end_cyl_low;
   logic [31:0] lba_start;
   logic [31:0] lba_count;

   modport source (output valid, status, boot_flag, start_head, start_sector_code,
                   start_cyl_low, type_code, end_head, end_sector_code, end_cyl_low,
                   lba_start, lba_count,
                   input ready);
   modport sink (input valid, status, boot_flag, start_head, start_sector_code,
                 start_cyl_low, type_code, end_head, end_sector_code, end_cyl_low,
                 lba_start, lba_count,
                 output ready);
endinterface

`default_nettype wire

// File: hdl/mpeb_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module mpeb_divider import mpeb_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [SectorsWidth-1:0]  dividend,
   input  wire logic [CylSizeWidth-1:0]  divisor,
   output logic                          done,
   output logic [SectorsWidth-1:0]       quotient
);

   localparam int StepWidth = $clog2(SectorsWidth);

   logic [SectorsWidth-1:0] quo_ff, quo_in;
   logic [CylSizeWidth-1:0] rem_ff, rem_in;
   logic [CylSizeWidth-1:0] dsr_ff, dsr_in;
   logic [StepWidth-1:0]    step_ff, step_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CylSizeWidth:0]   trial;
   logic [CylSizeWidth:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[SectorsWidth-1]};
      diff    = trial - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[CylSizeWidth-1:0];
            quo_in = {quo_ff[SectorsWidth-2:0], 1'b1};
         end else begin
            rem_in = trial[CylSizeWidth-1:0];
            quo_in = {quo_ff[SectorsWidth-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: hdl/mpeb_datapath.sv
`default_nettype none

module mpeb_datapath import mpeb_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [SectorsWidth-1:0] total_sectors,
   input  wire req_payload_type         req,
   input  wire mpeb_cmd_type            cmd,
   output mpeb_stat_type                stat,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output rsp_payload_type              rsp
);

   // request and geometry
   req_payload_type         req_ff;
   logic [CylSizeWidth-1:0] cyl_size_ff;
   logic [7:0]              heads_m1_ff;
   logic [HeadsWidth-1:0]   heads;

   // work registers
   logic [CylWidth-1:0]     tot_ff;
   logic [CylWidth-1:0]     pcyl_ff;
   logic [PctProdWidth-1:0] pct_prod_ff;
   logic [31:0]             start_ff;
   logic [31:0]             count_ff;

   // table state
   logic [CylWidth-1:0]        next_ff, next_in;
   logic [EntryCountWidth-1:0] entry_count_ff, entry_count_in;
   logic                       closed_ff, closed_in;

   // output register
   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic                      div_done;
   logic [SectorsWidth-1:0]   quotient;
   logic [CylWidth-1:0]       mul_a;
   logic [CylSizeWidth-1:0]   mul_b;
   logic [MulWidth-1:0]       product;
   logic [PctScaledWidth-1:0] pct_scaled;
   logic [CylWidth-1:0]       remain;
   logic [CylWidth:0]         ecyl;
   logic                      first_slot;
   logic [31:0]               track_adj;

   // heads double while the cylinder count would exceed the CHS limit
   always_comb begin
      heads = HeadsWidth'(MinHeads);
      for (int k = 0; k < HeadSteps; k++) begin
         if ({32'd0, total_sectors} >= (64'(HeadLimitSectors) << (MinHeadShift + k)))
            heads = HeadsWidth'(MinHeads << (k + 1));
      end
      if (heads == HeadsWidth'(MinHeads << HeadSteps))
         heads = HeadsWidth'(MaxHeads);
   end

   // iterative divider: total / cylinder size
   mpeb_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (total_sectors),
      .divisor  (cyl_size_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // shared multiplier, product always lands in a register
   always_comb begin
      case (cmd.mul_sel)
         MulPercent: begin
            mul_a = tot_ff;
            mul_b = CylSizeWidth'(req_ff.size_percent);
         end
         MulStart: begin
            mul_a = next_ff;
            mul_b = cyl_size_ff;
         end
         MulCount: begin
            mul_a = pcyl_ff;
            mul_b = cyl_size_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product    = MulWidth'(mul_a) * MulWidth'(mul_b);
   // percent share: product / 100 by reciprocal multiply and shift
   assign pct_scaled = PctScaledWidth'(pct_prod_ff) * PctScaledWidth'(PctRecip);
   assign remain     = (tot_ff > next_ff) ? (tot_ff - next_ff) : '0;
   assign ecyl       = {1'b0, next_ff} + {1'b0, pcyl_ff} - 1'b1;
   assign first_slot = (entry_count_ff == '0);
   assign track_adj  = first_slot ? 32'(SectorsPerTrack) : 32'd0;

   assign stat.ignore    = closed_ff || (entry_count_ff >= EntryCountWidth'(MaxEntries));
   assign stat.pct_zero  = (req_ff.size_percent == '0);
   assign stat.div_done  = div_done;
   assign stat.pcyl_zero = (pcyl_ff == '0);
   assign stat.no_space  = (ecyl >= {1'b0, tot_ff});
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in = '0;
      rsp_in.status = cmd.rsp_status;
      if (cmd.rsp_status != StatusIgnored) begin
         rsp_in.boot_flag = req_ff.active ? BootActive : 8'd0;
         rsp_in.type_code = req_ff.part_type;
      end
      if (cmd.rsp_status == StatusWritten) begin
         rsp_in.start_head        = first_slot;
         rsp_in.start_sector_code = {next_ff[9:8], 6'd1};
         rsp_in.start_cyl_low     = next_ff[7:0];
         rsp_in.end_head          = heads_m1_ff;
         rsp_in.end_sector_code   = {ecyl[9:8], 6'(SectorsPerTrack)};
         rsp_in.end_cyl_low       = ecyl[7:0];
         rsp_in.lba_start         = start_ff + track_adj;
         rsp_in.lba_count         = count_ff - track_adj;
      end
   end

   always_comb begin
      next_in        = next_ff;
      entry_count_in = entry_count_ff;
      closed_in      = closed_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (rsp_ready)
         rsp_valid_in = 1'b0;
      if (cmd.load_req && req.first_of_table) begin
         next_in        = '0;
         entry_count_in = '0;
         closed_in      = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         case (cmd.rsp_status)
            StatusWritten: begin
               next_in        = next_ff + pcyl_ff;
               entry_count_in = entry_count_ff + 1'b1;
            end
            StatusSkipped: entry_count_in = entry_count_ff + 1'b1;
            StatusAbort:   closed_in = 1'b1;
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff        <= '0;
         entry_count_ff <= '0;
         closed_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         next_ff        <= next_in;
         entry_count_ff <= entry_count_in;
         closed_ff      <= closed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff      <= req;
         cyl_size_ff <= CylSizeWidth'(heads * SectorsPerTrack);
         heads_m1_ff <= 8'(heads - 1'b1);
      end
      if (cmd.tot_load)
         tot_ff <= quotient[CylWidth-1:0];
      if (cmd.pcyl_load)
         pcyl_ff <= (cmd.pcyl_sel == PcylRemain) ? remain
                                                 : pct_scaled[PctRecipShift +: CylWidth];
      if (cmd.mul_load) begin
         case (cmd.mul_sel)
            MulPercent: pct_prod_ff <= product[PctProdWidth-1:0];
            MulStart:   start_ff    <= product[31:0];
            MulCount:   count_ff    <= product[31:0];
            default:    ;
         endcase
      end
      if (cmd.finish)
         rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// File: hdl/mpeb_ctrl.sv
`default_nettype none

module mpeb_ctrl import mpeb_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire mpeb_stat_type stat,
   output mpeb_cmd_type       cmd
);

   typedef enum logic [3:0] {
      StIdle,
      StCheck,
      StDivTot,
      StRemain,
      StPctMul,
      StPctScale,
      StEval,
      StMulStart,
      StMulCount,
      StFinish
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;

   always_comb begin
      cmd            = '0;
      cmd.rsp_status = status_ff;
      state_in       = state_ff;
      status_in      = status_ff;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = StCheck;
            end
         end
         StCheck: begin
            if (stat.ignore) begin
               status_in = StatusIgnored;
               state_in  = StFinish;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = StDivTot;
            end
         end
         StDivTot: begin
            if (stat.div_done) begin
               cmd.tot_load = 1'b1;
               state_in     = stat.pct_zero ? StRemain : StPctMul;
            end
         end
         StRemain: begin
            cmd.pcyl_load = 1'b1;
            cmd.pcyl_sel  = PcylRemain;
            state_in      = StEval;
         end
         StPctMul: begin
            cmd.mul_load = 1'b1;
            cmd.mul_sel  = MulPercent;
            state_in     = StPctScale;
         end
         StPctScale: begin
            cmd.pcyl_load = 1'b1;
            cmd.pcyl_sel  = PcylQuotient;
            state_in      = StEval;
         end
         StEval: begin
            if (stat.pcyl_zero) begin
               status_in = StatusSkipped;
               state_in  = StFinish;
            end else if (stat.no_space) begin
               status_in = StatusAbort;
               state_in  = StFinish;
            end else begin
               status_in = StatusWritten;
               state_in  = StMulStart;
            end
         end
         StMulStart: begin
            cmd.mul_load = 1'b1;
            cmd.mul_sel  = MulStart;
            state_in     = StMulCount;
         end
         StMulCount: begin
            cmd.mul_load = 1'b1;
            cmd.mul_sel  = MulCount;
            state_in     = StFinish;
         end
         StFinish: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= StIdle;
         status_ff <= StatusIgnored;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign req_ready = (state_ff == StIdle);

endmodule

`default_nettype wire

// File: hdl/mbr_partition_entry_builder.sv
// MBR partition entry builder. Write the disk's total sector count at CSR
// offset 0 first, then send one request beat per partition; each request beat
// yields exactly one response beat with the CHS and LBA fields of the entry and
// a status (written, zero size skipped, no space abort, ignored). Geometry:
// 63 sectors per track, heads 16/32/64/128/255 picked from the sector count.
// first_of_table restarts the table; the first slot gives up its first track.
// One request is in flight at a time. An ignored request is answered without
// running the divider; every other request waits for the 32-step divider that
// finds the cylinder count, and a percent request then also runs a reciprocal
// multiply for its share. The next request is taken while a response beat
// still waits at the output.
`default_nettype none

module mbr_partition_entry_builder import mpeb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // CSR port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   // channels
   mpeb_req_if.sink         req_ch,
   mpeb_rsp_if.source       rsp_ch
);

   logic [SectorsWidth-1:0] total_sectors_ff, total_sectors_in;
   logic                    csr_write;
   req_payload_type         req_payload;
   rsp_payload_type         rsp_payload;
   mpeb_cmd_type            cmd;
   mpeb_stat_type           stat;
   logic                    req_ready;
   logic                    rsp_valid;

   // CSR: single write/read register, no wait states
   assign csr_write        = csr_psel && csr_penable && csr_pwrite
                             && (csr_paddr == CsrTotalSectors);
   assign total_sectors_in = csr_write ? csr_pwdata : total_sectors_ff;
   assign csr_pready       = 1'b1;
   assign csr_prdata       = (csr_paddr == CsrTotalSectors) ? total_sectors_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_sectors_ff <= '0;
      end else begin
         total_sectors_ff <= total_sectors_in;
      end
   end

   assign req_payload.first_of_table = req_ch.first_of_table;
   assign req_payload.active         = req_ch.active;
   assign req_payload.part_type      = req_ch.part_type;
   assign req_payload.size_percent   = req_ch.size_percent;
   assign req_ch.ready               = req_ready;

   mpeb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mpeb_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .total_sectors (total_sectors_ff),
      .req           (req_payload),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp           (rsp_payload)
   );

   // response beat straight from the output register
   assign rsp_ch.valid             = rsp_valid;
   assign rsp_ch.status            = rsp_payload.status;
   assign rsp_ch.boot_flag         = rsp_payload.boot_flag;
   assign rsp_ch.start_head        = rsp_payload.start_head;
   assign rsp_ch.start_sector_code = rsp_payload.start_sector_code;
   assign rsp_ch.start_cyl_low     = rsp_payload.start_cyl_low;
   assign rsp_ch.type_code         = rsp_payload.type_code;
   assign rsp_ch.end_head          = rsp_payload.end_head;
   assign rsp_ch.end_sector_code   = rsp_payload.end_sector_code;
   assign rsp_ch.end_cyl_low       = rsp_payload.end_cyl_low;
   assign rsp_ch.lba_start         = rsp_payload.lba_start;
   assign rsp_ch.lba_count         = rsp_payload.lba_count;

   // one request in flight: ready drops right after a request beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while another is in flight");

   // ignored requests carry nothing but the status
   a_ignored_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == StatusIgnored)
      |-> (rsp_payload.boot_flag == 8'd0) && (rsp_payload.type_code == 8'd0)
          && (rsp_payload.lba_count == 32'd0))
      else $error("ignored response has nonzero fields");

   // a written entry always covers sectors and has a real head count
   a_written_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == StatusWritten)
      |-> (rsp_payload.lba_count != 32'd0) && (rsp_payload.end_head != 8'd0))
      else $error("written entry is empty");

endmodule

`default_nettype wire
